FILE: hdl/sfdg_pkg.sv
// shared types and constants for the seismic sample decoder with gain
// used by the decode stage, the scale stage and the top level
package sfdg_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned MantW    = 24;
  localparam int unsigned GainW    = 16;
  localparam int unsigned ProdW    = MantW + GainW;
  localparam int unsigned ShW      = 10;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam int IbmBias   = 64;
  localparam int IeeeBias  = 127;
  localparam int IbmFracW  = 24;
  localparam int IeeeFracW = 23;

  localparam logic [CfgIdxW-1:0] RegFormat = 8'd0;
  localparam logic [CfgIdxW-1:0] RegGain   = 8'd1;

  typedef enum logic {
    FmtIbm  = 1'b0,
    FmtIeee = 1'b1
  } fmt_e;

  // decoded word between the two pipeline stages
  typedef struct packed {
    logic [ProdW-1:0]     prod;
    logic signed [ShW-1:0] sh;
    logic                 neg;
    logic                 zero;
    logic                 force_sat;
  } stage_t;

endpackage

FILE: hdl/sfdg_decode.sv
// first stage: splits the sample word by format, multiplies by the gain
// and registers product, binary exponent and special-case flags; uses sfdg_pkg
module sfdg_decode #(
  parameter int OUT_FRAC_BITS  = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sfdg_pkg::fmt_e                 fmt_i,
  input  logic [sfdg_pkg::GainW-1:0]     gain_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [sfdg_pkg::WordW-1:0]     sample_word_i,
  output logic                           st_valid_o,
  input  logic                           st_ready_i,
  output sfdg_pkg::stage_t               st_o
);
  import sfdg_pkg::*;

  localparam int IbmOfs  = -4 * IbmBias - IbmFracW - GAIN_FRAC_BITS + OUT_FRAC_BITS;
  localparam int IeeeOfs = -IeeeBias - IeeeFracW - GAIN_FRAC_BITS + OUT_FRAC_BITS;

  logic [6:0]       ibm_exp;
  logic [7:0]       ieee_exp;
  logic [MantW-1:0] mant;
  logic             valid_q;
  stage_t           st_d, st_q;

  assign ibm_exp  = sample_word_i[30:24];
  assign ieee_exp = sample_word_i[30:23];

  always_comb begin
    st_d = '0;
    st_d.neg = sample_word_i[31];
    if (fmt_i == FmtIbm) begin
      mant           = sample_word_i[MantW-1:0];
      st_d.sh        = ShW'(int'(ibm_exp) * 4 + IbmOfs);
      st_d.force_sat = 1'b0;
      st_d.zero      = (mant == '0) || (gain_i == '0);
    end else begin
      mant           = {1'b1, sample_word_i[22:0]};
      st_d.sh        = ShW'(int'(ieee_exp) + IeeeOfs);
      st_d.force_sat = (ieee_exp == 8'hFF);
      st_d.zero      = (ieee_exp == 8'h00) || (gain_i == '0);
    end
    st_d.prod = ProdW'(mant) * ProdW'(gain_i);
  end

  assign in_ready_o = !valid_q || st_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      st_q <= st_d;
    end
  end

  assign st_valid_o = valid_q;
  assign st_o       = st_q;

endmodule

FILE: hdl/sfdg_scale.sv
// second stage: shifts the product by its exponent, rounds half up,
// saturates, applies the sign and holds the result word; uses sfdg_pkg
module sfdg_scale (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           st_valid_i,
  output logic                           st_ready_o,
  input  sfdg_pkg::stage_t               st_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [sfdg_pkg::WordW-1:0] sample_value_o,
  output logic                           saturated_o
);
  import sfdg_pkg::*;

  localparam int unsigned WideW = ProdW + WordW;
  localparam int unsigned NW    = 6;

  logic [WordW:0]         limit;
  logic [WideW-1:0]       wide;
  logic [ShW-1:0]         n;
  logic [ProdW-1:0]       pre;
  logic [ProdW:0]         rnd;
  logic [WordW:0]         mag;
  logic                   sat;
  logic [WordW-1:0]       value_d, value_q;
  logic                   sat_q, valid_q;

  always_comb begin
    limit = st_i.neg ? {1'b0, 1'b1, {(WordW-1){1'b0}}} : {2'b00, {(WordW-1){1'b1}}};
    n     = ShW'(-st_i.sh);
    wide  = WideW'(st_i.prod) << st_i.sh[4:0];
    pre   = st_i.prod >> (n[NW-1:0] - NW'(1));
    rnd   = ((ProdW+1)'(pre) + (ProdW+1)'(1)) >> 1;
    mag   = '0;
    sat   = 1'b0;
    if (st_i.force_sat) begin
      sat = 1'b1;
      mag = limit;
    end else if (st_i.zero) begin
      mag = '0;
    end else if (!st_i.sh[ShW-1]) begin
      if (st_i.sh >= ShW'(WordW) || wide > WideW'(limit)) begin
        sat = 1'b1;
        mag = limit;
      end else begin
        mag = wide[WordW:0];
      end
    end else if (n > ShW'(ProdW)) begin
      mag = '0;
    end else if (rnd > (ProdW+1)'(limit)) begin
      sat = 1'b1;
      mag = limit;
    end else begin
      mag = rnd[WordW:0];
    end
    value_d = st_i.neg ? (WordW'(0) - mag[WordW-1:0]) : mag[WordW-1:0];
  end

  assign st_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (st_ready_o) begin
      valid_q <= st_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_ready_o && st_valid_i) begin
      value_q <= value_d;
      sat_q   <= sat;
    end
  end

  assign out_valid_o    = valid_q;
  assign sample_value_o = value_q;
  assign saturated_o    = sat_q;

endmodule

FILE: hdl/sample_float_decode_gain_core.sv
// top level of the seismic sample decoder: IBM hex or IEEE single word in,
// gain-scaled signed fixed point word out; uses sfdg_pkg, sfdg_decode, sfdg_scale
// path: each input word is registered in the decode stage, then in the scale stage, before out_valid_o rises
// throughput: one word per cycle while out_ready_i is held high, set by the decode/multiply and scale registers
// reset: pipeline empty, format IBM, gain 256 (1.0 with GAIN_FRAC_BITS 8); config writes always taken
module sample_float_decode_gain_core #(
  parameter int OUT_FRAC_BITS  = 16,
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sfdg_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sfdg_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sfdg_pkg::WordW-1:0]         sample_word_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [sfdg_pkg::WordW-1:0]  sample_value_o,
  output logic                               saturated_o
);
  import sfdg_pkg::*;

  fmt_e             fmt_q;
  logic [GainW-1:0] gain_q;
  logic             st_valid, st_ready;
  stage_t           st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= FmtIbm;
      gain_q <= GainW'(256);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegFormat: fmt_q  <= fmt_e'(cfg_data_i[0]);
        RegGain:   gain_q <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  sfdg_decode #(
    .OUT_FRAC_BITS  (OUT_FRAC_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fmt_i         (fmt_q),
    .gain_i        (gain_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_word_i (sample_word_i),
    .st_valid_o    (st_valid),
    .st_ready_i    (st_ready),
    .st_o          (st)
  );

  sfdg_scale u_scale (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .st_valid_i     (st_valid),
    .st_ready_o     (st_ready),
    .st_i           (st),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_value_o (sample_value_o),
    .saturated_o    (saturated_o)
  );

endmodule
